[design/ipal_pkg.sv]
package ipal_pkg;

    localparam int TABLE_ENTRIES = 16;

    localparam int ADDR_BITS = 32;
    localparam int PLEN_BITS = 6;
    localparam int IDX_BITS  = $clog2(TABLE_ENTRIES);

    localparam logic [PLEN_BITS-1:0] PLEN_MAX  = 6'd32;
    localparam logic [ADDR_BITS-1:0] ADDR_ONES = 32'hffff_ffff;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_DUP    = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;
    localparam logic [1:0] STATUS_BADLEN = 2'd3;

    typedef struct packed {
        logic [1:0]           op;
        logic [ADDR_BITS-1:0] address;
        logic [PLEN_BITS-1:0] prefix_len;
    } req_t;

    typedef struct packed {
        logic       blocked;
        logic [1:0] status;
    } rsp_t;

    // Travels down the cell row, one cell per cycle.
    typedef struct packed {
        logic                live;
        logic                match;
        logic                dup;
        logic                free_found;
        logic [IDX_BITS-1:0] free_idx;
    } carry_t;

    // Table update, broadcast to every cell.
    typedef struct packed {
        logic                 clear;
        logic                 add;
        logic [IDX_BITS-1:0]  idx;
        logic [ADDR_BITS-1:0] address;
        logic [PLEN_BITS-1:0] prefix_len;
    } wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESULT
    } state_t;

    function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic [PLEN_BITS-1:0] plen);
        logic [ADDR_BITS-1:0] m;
        if (plen >= PLEN_MAX)
        begin
            m = ADDR_ONES;
        end
        else
        begin
            m = ~(ADDR_ONES >> plen);
        end
        return m;
    endfunction

endpackage

[design/ipal_cell.sv]
module ipal_cell #(
    parameter int INDEX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ipal_pkg::carry_t                    carry_in,
    output ipal_pkg::carry_t                    carry_out,
    input  logic [ipal_pkg::ADDR_BITS-1:0]      req_address,
    input  logic [ipal_pkg::PLEN_BITS-1:0]      req_prefix_len,
    input  ipal_pkg::wr_t                       wr
);

    localparam logic [ipal_pkg::IDX_BITS-1:0] MY_IDX = ipal_pkg::IDX_BITS'(INDEX);

    logic                             valid_reg;
    logic [ipal_pkg::ADDR_BITS-1:0]   addr_reg;
    logic [ipal_pkg::PLEN_BITS-1:0]   plen_reg;
    ipal_pkg::carry_t                 carry_reg;
    ipal_pkg::carry_t                 carry_next;
    logic [ipal_pkg::ADDR_BITS-1:0]   mask;
    logic                             hit;
    logic                             same;
    logic                             take;

    assign take = wr.add && (wr.idx == MY_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            addr_reg <= wr.address;
            plen_reg <= wr.prefix_len;
        end
    end

    assign mask = ipal_pkg::prefix_mask(plen_reg);
    assign hit  = valid_reg && (((req_address ^ addr_reg) & mask) == '0);
    assign same = valid_reg && (req_address == addr_reg) && (req_prefix_len == plen_reg);

    always_comb
    begin
        carry_next            = carry_in;
        carry_next.match      = carry_in.match | hit;
        carry_next.dup        = carry_in.dup | same;
        if (!carry_in.free_found && !valid_reg)
        begin
            carry_next.free_found = 1'b1;
            carry_next.free_idx   = MY_IDX;
        end
        if (!carry_in.live)
        begin
            carry_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
        end
    end

    assign carry_out = carry_reg;

endmodule

[design/ipal_ctrl.sv]
module ipal_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  ipal_pkg::req_t        req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output ipal_pkg::rsp_t        rsp,
    output ipal_pkg::req_t        cur,
    output ipal_pkg::carry_t      head,
    input  ipal_pkg::carry_t      tail,
    output ipal_pkg::wr_t         wr
);

    ipal_pkg::state_t state_reg;
    ipal_pkg::state_t state_next;
    ipal_pkg::req_t   req_reg;
    ipal_pkg::carry_t res_reg;
    logic             go_reg;
    logic             rsp_valid_reg;
    ipal_pkg::rsp_t   rsp_reg;
    ipal_pkg::rsp_t   rsp_next;
    logic             accept;
    logic             load;

    assign accept = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ipal_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ipal_pkg::ST_WALK;
                end
            end
            ipal_pkg::ST_WALK:
            begin
                if (tail.live)
                begin
                    state_next = ipal_pkg::ST_RESULT;
                end
            end
            ipal_pkg::ST_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = ipal_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ipal_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        load      = 1'b0;
        case (state_reg)
            ipal_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            ipal_pkg::ST_RESULT:
            begin
                load = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // Result and table update from the finished walk.
    always_comb
    begin
        rsp_next = '0;
        case (req_reg.op)
            ipal_pkg::OP_ADD:
            begin
                if (req_reg.prefix_len > ipal_pkg::PLEN_MAX)
                begin
                    rsp_next.status = ipal_pkg::STATUS_BADLEN;
                end
                else if (res_reg.dup)
                begin
                    rsp_next.status = ipal_pkg::STATUS_DUP;
                end
                else if (!res_reg.free_found)
                begin
                    rsp_next.status = ipal_pkg::STATUS_FULL;
                end
                else
                begin
                    rsp_next.status = ipal_pkg::STATUS_OK;
                end
            end
            ipal_pkg::OP_CHECK:
            begin
                rsp_next.blocked = !res_reg.match;
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_comb
    begin
        wr            = '0;
        wr.clear      = load && (req_reg.op == ipal_pkg::OP_CLEAR);
        wr.add        = load && (req_reg.op == ipal_pkg::OP_ADD)
                        && (rsp_next.status == ipal_pkg::STATUS_OK);
        wr.idx        = res_reg.free_idx;
        wr.address    = req_reg.address;
        wr.prefix_len = req_reg.prefix_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ipal_pkg::ST_IDLE;
            go_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= accept;
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (tail.live)
        begin
            res_reg <= tail;
        end
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb
    begin
        head      = '0;
        head.live = go_reg;
    end

    assign cur       = req_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[design/ipv4_prefix_allow_list.sv]
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | ipal_pkg::req_t (op, address, prefix_len)
// rsp     | out       | rsp_valid/rsp_stall  | ipal_pkg::rsp_t (blocked, status)
//
// A new request is accepted only while idle, once the previous one has finished:
// the request walks the row of entry cells, one cell per cycle, then the result
// state forms the result and applies any table update.
// Reset clears every valid bit and the control state; entry contents stay
// undefined until an add writes them.
// A stalled result waits in the output register; only a new result waits on it.
module ipv4_prefix_allow_list (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ipal_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ipal_pkg::rsp_t rsp
);

    localparam int TABLE_ENTRIES = ipal_pkg::TABLE_ENTRIES;

    ipal_pkg::req_t   cur;
    ipal_pkg::wr_t    wr;
    ipal_pkg::carry_t chain [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] live;

    // Sequence requests, hold the request fields during the walk, and
    // turn the carry that leaves the last cell into a result.
    ipal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cur       (cur),
        .head      (chain[0]),
        .tail      (chain[TABLE_ENTRIES]),
        .wr        (wr)
    );

    // One cell per table entry; each folds its own match, duplicate and
    // free-slot findings into the carry and hands it on.
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        ipal_cell #(
            .INDEX (i)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .carry_in       (chain[i]),
            .carry_out      (chain[i+1]),
            .req_address    (cur.address),
            .req_prefix_len (cur.prefix_len),
            .wr             (wr)
        );
        assign live[i] = chain[i+1].live;
    end

`ifndef SYNTH
    // Only one request is ever in the row.
    a_one_live: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(live))
        else $error("more than one request in the cell row");

    // A new request only enters an empty row.
    a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> (live == '0))
        else $error("request accepted while the row is busy");

    // An accepted request passes the go register and then reaches the first cell.
    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> ##1 live[0])
        else $error("walk did not start");

    // Table updates happen only once the walk has drained.
    a_wr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.add || wr.clear) |-> (live == '0))
        else $error("table written during a walk");
`endif

endmodule

[verif/tb_ipv4_prefix_allow_list.sv]
`timescale 1ns / 100ps

module tb_ipv4_prefix_allow_list;

    localparam int TABLE_ENTRIES = ipal_pkg::TABLE_ENTRIES;
    localparam int ADDR_BITS     = ipal_pkg::ADDR_BITS;
    localparam int PLEN_BITS     = ipal_pkg::PLEN_BITS;
    // One request walks every entry cell, then the result is formed.
    localparam int WALK_CYCLES   = TABLE_ENTRIES + 3;
    // Cycles without any accepted request or response before giving up.
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 205;

    // Op code the block must ignore: no table change, all-zero response.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        ipal_pkg::req_t r;
        int unsigned    phase;
    } pending_req_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    ipal_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    ipal_pkg::rsp_t rsp;

    // Idle percentages per phase: receiver stalls most, then sender idles most, then none.
    int unsigned send_idle_pct[3]  = '{27, 68, 0};
    int unsigned recv_stall_pct[3] = '{68, 27, 0};
    int unsigned cur_phase;

    pending_req_t   request_queue[$];
    ipal_pkg::rsp_t verdict_queue[$];

    // Shadow copy of the allow list.
    logic [ADDR_BITS-1:0] acl_addr[TABLE_ENTRIES];
    logic [PLEN_BITS-1:0] acl_plen[TABLE_ENTRIES];
    logic                 acl_used[TABLE_ENTRIES];

    int unsigned mismatches;
    int unsigned quiet_cycles;

    // Stimulus generator bookkeeping.
    int unsigned          gen_phase;
    int unsigned          gen_count;
    logic [ADDR_BITS-1:0] hint_addr[$];
    logic [PLEN_BITS-1:0] hint_plen[$];

    ipv4_prefix_allow_list dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always #5 clk = ~clk;

    // Leading-ones network mask; only called with lengths of 32 or less.
    function automatic logic [ADDR_BITS-1:0] net_mask(input logic [PLEN_BITS-1:0] plen);
        logic [ADDR_BITS-1:0] m;
        if (plen == '0)
        begin
            m = '0;
        end
        else
        begin
            m = {ADDR_BITS{1'b1}} << (6'd32 - plen);
        end
        return m;
    endfunction

    // Apply one request to the shadow table and return the verdict it earns.
    function automatic ipal_pkg::rsp_t acl_verdict(input ipal_pkg::req_t r);
        ipal_pkg::rsp_t       v;
        int                   slot;
        logic                 dup;
        logic [ADDR_BITS-1:0] m;
        v    = '0;
        slot = -1;
        dup  = 1'b0;
        case (r.op)
            ipal_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    acl_used[i] = 1'b0;
                end
            end
            ipal_pkg::OP_ADD:
            begin
                // Order of rejection: bad length, then duplicate, then full.
                if (r.prefix_len > ipal_pkg::PLEN_MAX)
                begin
                    v.status = ipal_pkg::STATUS_BADLEN;
                end
                else
                begin
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        if (acl_used[i])
                        begin
                            if (acl_addr[i] == r.address && acl_plen[i] == r.prefix_len)
                            begin
                                dup = 1'b1;
                            end
                        end
                        else if (slot < 0)
                        begin
                            slot = i;
                        end
                    end
                    if (dup)
                    begin
                        v.status = ipal_pkg::STATUS_DUP;
                    end
                    else if (slot < 0)
                    begin
                        v.status = ipal_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        // Take the lowest free slot.
                        acl_addr[slot] = r.address;
                        acl_plen[slot] = r.prefix_len;
                        acl_used[slot] = 1'b1;
                    end
                end
            end
            ipal_pkg::OP_CHECK:
            begin
                // Empty table blocks everything.
                v.blocked = 1'b1;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (acl_used[i])
                    begin
                        m = net_mask(acl_plen[i]);
                        if ((r.address & m) == (acl_addr[i] & m))
                        begin
                            v.blocked = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return v;
    endfunction

    task automatic push_request(input logic [1:0] op, input logic [ADDR_BITS-1:0] addr,
                                input logic [PLEN_BITS-1:0] plen);
        pending_req_t p;
        p.r.op         = op;
        p.r.address    = addr;
        p.r.prefix_len = plen;
        p.phase        = gen_phase;
        request_queue.insert(request_queue.size(), p);
        gen_count++;
    endtask

    // Mostly mid-range lengths, a few short ones, a few invalid ones.
    function automatic logic [PLEN_BITS-1:0] pick_plen();
        int unsigned r;
        r = $urandom_range(15);
        if (r == 0)
        begin
            return PLEN_BITS'($urandom_range(63, 33));
        end
        else if (r == 1)
        begin
            return PLEN_BITS'($urandom_range(7, 0));
        end
        return PLEN_BITS'($urandom_range(32, 8));
    endfunction

    task automatic add_entry(input logic [ADDR_BITS-1:0] addr, input logic [PLEN_BITS-1:0] plen);
        push_request(ipal_pkg::OP_ADD, addr, plen);
        if (plen <= ipal_pkg::PLEN_MAX)
        begin
            hint_addr.insert(hint_addr.size(), addr);
            hint_plen.insert(hint_plen.size(), plen);
        end
    endtask

    // Probe the table: hit inside a known network, miss by the last prefix bit,
    // or try a fully random address.
    task automatic probe_address();
        int unsigned          k;
        int unsigned          how;
        logic [ADDR_BITS-1:0] m;
        logic [ADDR_BITS-1:0] a;
        how = $urandom_range(3);
        a   = $urandom();
        if (hint_addr.size() != 0 && how != 0)
        begin
            k = $urandom_range(hint_addr.size() - 1);
            m = net_mask(hint_plen[k]);
            a = (hint_addr[k] & m) | (a & ~m);
            if (how == 3 && hint_plen[k] != '0)
            begin
                a = a ^ (32'h1 << (6'd32 - hint_plen[k]));
            end
        end
        push_request(ipal_pkg::OP_CHECK, a, PLEN_BITS'($urandom_range(63)));
    endtask

    // Clear (usually), fill with networks and some re-adds, then probe.
    task automatic table_sequence();
        int unsigned n;
        int unsigned k;
        if ($urandom_range(3) != 0)
        begin
            push_request(ipal_pkg::OP_CLEAR, $urandom(), PLEN_BITS'($urandom_range(63)));
            hint_addr.delete();
            hint_plen.delete();
        end
        // Now and then overfill to reach the full table.
        n = ($urandom_range(4) == 0) ? $urandom_range(19, 14) : $urandom_range(6, 1);
        for (int i = 0; i < n; i++)
        begin
            if (hint_addr.size() != 0 && $urandom_range(7) == 0)
            begin
                k = $urandom_range(hint_addr.size() - 1);
                push_request(ipal_pkg::OP_ADD, hint_addr[k], hint_plen[k]);
            end
            else
            begin
                add_entry($urandom(), pick_plen());
            end
        end
        n = $urandom_range(8, 2);
        for (int i = 0; i < n; i++)
        begin
            probe_address();
        end
    endtask

    task automatic noise_burst();
        int unsigned n;
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++)
        begin
            push_request(2'($urandom_range(3)), $urandom(), PLEN_BITS'($urandom_range(63)));
        end
    endtask

    task automatic directed_requests();
        // Empty table blocks even the zero address.
        push_request(ipal_pkg::OP_CHECK, 32'h0000_0000, 6'd0);
        // Invalid lengths, just above the limit and at the top of the field.
        push_request(ipal_pkg::OP_ADD, 32'hc0a8_0100, 6'd33);
        push_request(ipal_pkg::OP_ADD, 32'hffff_ffff, 6'd63);
        push_request(ipal_pkg::OP_ADD, 32'hc0a8_0100, 6'd24);
        push_request(ipal_pkg::OP_ADD, 32'hc0a8_0100, 6'd24);
        // Same network, different host bits: a distinct entry.
        push_request(ipal_pkg::OP_ADD, 32'hc0a8_01ff, 6'd24);
        // Same address, other length: also distinct.
        push_request(ipal_pkg::OP_ADD, 32'hc0a8_0100, 6'd23);
        push_request(ipal_pkg::OP_CHECK, 32'hc0a8_01ab, 6'd63);
        push_request(ipal_pkg::OP_CHECK, 32'hc0a8_0200, 6'd0);
        push_request(ipal_pkg::OP_CHECK, 32'hc0a9_0000, 6'd0);
        push_request(ipal_pkg::OP_ADD, 32'hffff_ffff, 6'd32);
        push_request(ipal_pkg::OP_CHECK, 32'hffff_ffff, 6'd0);
        push_request(ipal_pkg::OP_CHECK, 32'hffff_fffe, 6'd0);
        // Ignored op with every input bit set.
        push_request(OP_UNUSED, 32'hffff_ffff, 6'd63);
        push_request(ipal_pkg::OP_CHECK, 32'hc0a8_01ab, 6'd0);
        push_request(ipal_pkg::OP_CLEAR, 32'hffff_ffff, 6'd63);
        push_request(ipal_pkg::OP_CHECK, 32'hc0a8_01ab, 6'd0);
        // Length zero matches every address.
        push_request(ipal_pkg::OP_ADD, 32'h0000_0000, 6'd0);
        push_request(ipal_pkg::OP_CHECK, 32'hdead_beef, 6'd0);
        push_request(ipal_pkg::OP_ADD, 32'h1234_5678, 6'd0);
        push_request(ipal_pkg::OP_ADD, 32'h8000_0000, 6'd1);
        push_request(ipal_pkg::OP_CHECK, 32'h7fff_ffff, 6'd32);
        push_request(ipal_pkg::OP_CLEAR, 32'h0000_0000, 6'd0);
        push_request(ipal_pkg::OP_CHECK, 32'h7fff_ffff, 6'd0);
    endtask

    // Driver: present the next request, hold it while stalled, idle at random.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                verdict_queue.insert(verdict_queue.size(), acl_verdict(req));
                void'(request_queue.pop_front());
            end
            // A stalled request stays on the bus untouched.
            if (!(req_valid && req_stall))
            begin
                if (request_queue.size() != 0
                    && $urandom_range(99) >= send_idle_pct[request_queue[0].phase])
                begin
                    req_valid <= 1'b1;
                    req       <= request_queue[0].r;
                    cur_phase <= request_queue[0].phase;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every accepted response with the oldest verdict.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (verdict_queue.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual %0d/%0d",
                             $time, rsp.blocked, rsp.status);
                    mismatches++;
                end
                else
                begin
                    if (rsp.blocked !== verdict_queue[0].blocked)
                    begin
                        $display("%0t: blocked mismatch, expected %0d, actual %0d",
                                 $time, verdict_queue[0].blocked, rsp.blocked);
                        mismatches++;
                    end
                    if (rsp.status !== verdict_queue[0].status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, verdict_queue[0].status, rsp.status);
                        mismatches++;
                    end
                    void'(verdict_queue.pop_front());
                end
            end
            rsp_stall <= ($urandom_range(99) < recv_stall_pct[cur_phase]);
        end
    end

    // Watchdog: bail out when neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        rsp_stall    = 1'b0;
        cur_phase    = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            acl_addr[i] = '0;
            acl_plen[i] = '0;
            acl_used[i] = 1'b0;
        end

        // Build the whole stimulus up front; each request carries its idle phase.
        gen_phase = 0;
        gen_count = 0;
        directed_requests();
        for (int p = 0; p < 3; p++)
        begin
            gen_phase = p;
            gen_count = 0;
            while (gen_count < PHASE_ITEMS)
            begin
                if ($urandom_range(9) < 8)
                begin
                    table_sequence();
                end
                else
                begin
                    noise_burst();
                end
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every request sent and every verdict matched, then linger.
        while (request_queue.size() != 0 || verdict_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4 * WALK_CYCLES) @(posedge clk);

        if (mismatches == 0 && verdict_queue.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
